[src/vfcm_pkg.sv]
package vfcm_pkg;

  localparam int unsigned ChunkSizeDef = 16;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_FILL  = 2'd1;
  localparam logic [1:0] REQ_FACES = 2'd2;

  // Voxel types
  localparam logic [2:0] VT_AIR     = 3'd0;
  localparam logic [2:0] VT_GRASS   = 3'd1;
  localparam logic [2:0] VT_DIRT    = 3'd2;
  localparam logic [2:0] VT_STONE   = 3'd3;
  localparam logic [2:0] VT_BEDROCK = 3'd4;

  // Face directions, in scan order
  localparam logic [2:0] DIR_PX = 3'd0;
  localparam logic [2:0] DIR_PY = 3'd1;
  localparam logic [2:0] DIR_NX = 3'd2;
  localparam logic [2:0] DIR_NY = 3'd3;
  localparam logic [2:0] DIR_PZ = 3'd4;
  localparam logic [2:0] DIR_NZ = 3'd5;

  localparam int unsigned NumDirs = 6;

  // dir * 255 / 6
  function automatic logic [7:0] shade_of(logic [2:0] dir);
    logic [7:0] s;
    unique case (dir)
      DIR_PX:  s = 8'd0;
      DIR_PY:  s = 8'd42;
      DIR_NX:  s = 8'd85;
      DIR_NY:  s = 8'd127;
      DIR_PZ:  s = 8'd170;
      DIR_NZ:  s = 8'd212;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

[src/voxel_face_culling_mesher.sv]
// Voxel face culling mesher.
// Input channel (in_valid_i/in_ready_o) takes one request word: write a voxel,
// fill a terrain column from a height, or query the visible faces of a voxel.
// Output channel (out_valid_o/out_ready_i) returns face records; only a face
// query produces records (one per visible face in +x,+y,-x,-y,+z,-z order, or
// a single record with face_valid_o low), last_o marks the final record.
// All state sits in one voxel memory with a registered read, so
// one request is in work at a time; in_ready_o is high whenever the
// sequencer is idle.
// Column fill writes one layer per cycle, from the peak down to bedrock.
// Face query: the voxel is read first, then the six neighbors (one memory
// read per cycle), then one record per cycle while the output is free; an
// air or out-of-chunk voxel skips the neighbor scan.
// After reset the memory is swept to air, one entry per cycle, over all
// 2^(3*clog2(CHUNK_SIZE)) entries (4096 at the default); no request is taken
// meanwhile. A stalled receiver holds the record in the output register and
// freezes record emission; new requests wait until the query is done.
module voxel_face_culling_mesher
  import vfcm_pkg::*;
#(
  parameter int unsigned CHUNK_SIZE = ChunkSizeDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [3:0] pos_x_i,
  input  logic [3:0] pos_y_i,
  input  logic [3:0] pos_z_i,
  input  logic [2:0] new_type_i,
  input  logic [4:0] height_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       face_valid_o,
  output logic [2:0] direction_o,
  output logic [2:0] voxel_type_o,
  output logic [3:0] face_x_o,
  output logic [3:0] face_y_o,
  output logic [3:0] face_z_o,
  output logic [7:0] shade_o,
  output logic       last_o
);

  localparam int unsigned CW    = $clog2(CHUNK_SIZE);
  localparam int unsigned AW    = 3 * CW;
  localparam int unsigned Depth = 1 << AW;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FILL  = 6'b000100,
    S_SELF  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Voxel memory
  logic [2:0]    mem [Depth];
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [2:0]    wr_data, rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  // Working registers
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [3:0]    px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [CW-1:0] fz_q, fz_d, pk_q, pk_d;
  logic [2:0]    vt_q, vt_d;
  logic [2:0]    dir_q, dir_d;
  logic          nb_out_q, nb_out_d;
  logic [NumDirs-1:0] mask_q, mask_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic       o_fv_q, o_fv_d, o_last_q, o_last_d;
  logic [2:0] o_dir_q, o_dir_d, o_vt_q, o_vt_d;
  logic [3:0] o_x_q, o_x_d, o_y_q, o_y_d, o_z_q, o_z_d;
  logic [7:0] o_sh_q, o_sh_d;

  logic in_acc, out_free;
  logic x_ok, y_ok, z_ok;
  logic [6:0] h_inc, peak;
  logic [CW-1:0] nx, ny, nz;
  logic nb_outside;
  logic [2:0] sel;
  logic [NumDirs-1:0] sel_oh, rem;
  logic [CW-1:0] fz_gap;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign x_ok = {4'b0, pos_x_i} < 8'(CHUNK_SIZE);
  assign y_ok = {4'b0, pos_y_i} < 8'(CHUNK_SIZE);
  assign z_ok = {4'b0, pos_z_i} < 8'(CHUNK_SIZE);

  assign h_inc = {2'b0, height_i} + 7'd1;
  assign peak  = (h_inc > 7'(CHUNK_SIZE - 1)) ? 7'(CHUNK_SIZE - 1) : h_inc;

  assign fz_gap = pk_q - fz_q;

  // Neighbor of the queried voxel in direction dir_q
  always_comb begin
    nx = cx_q;
    ny = cy_q;
    nz = cz_q;
    nb_outside = 1'b0;
    unique case (dir_q)
      DIR_PX: begin
        nx = cx_q + CW'(1);
        nb_outside = (cx_q == CW'(CHUNK_SIZE - 1));
      end
      DIR_PY: begin
        ny = cy_q + CW'(1);
        nb_outside = (cy_q == CW'(CHUNK_SIZE - 1));
      end
      DIR_NX: begin
        nx = cx_q - CW'(1);
        nb_outside = (cx_q == '0);
      end
      DIR_NY: begin
        ny = cy_q - CW'(1);
        nb_outside = (cy_q == '0);
      end
      DIR_PZ: begin
        nz = cz_q + CW'(1);
        nb_outside = (cz_q == CW'(CHUNK_SIZE - 1));
      end
      DIR_NZ: begin
        nz = cz_q - CW'(1);
        nb_outside = (cz_q == '0);
      end
      default: nb_outside = 1'b1;
    endcase
  end

  // Lowest pending visible face
  always_comb begin
    sel = '0;
    for (int i = NumDirs - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = 3'(i);
    end
    sel_oh = NumDirs'(1) << sel;
    rem    = mask_q & ~sel_oh;
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    px_d     = px_q;
    py_d     = py_q;
    pz_d     = pz_q;
    fz_d     = fz_q;
    pk_d     = pk_q;
    vt_d     = vt_q;
    dir_d    = dir_q;
    nb_out_d = nb_out_q;
    mask_d   = mask_q;

    out_valid_d = out_valid_q && !out_ready_i;
    o_fv_d   = o_fv_q;
    o_last_d = o_last_q;
    o_dir_d  = o_dir_q;
    o_vt_d   = o_vt_q;
    o_x_d    = o_x_q;
    o_y_d    = o_y_q;
    o_z_d    = o_z_q;
    o_sh_d   = o_sh_q;

    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = VT_AIR;
    rd_en   = 1'b0;
    rd_addr = {CW'(pos_z_i), CW'(pos_y_i), CW'(pos_x_i)};

    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        cx_d   = CW'(pos_x_i);
        cy_d   = CW'(pos_y_i);
        cz_d   = CW'(pos_z_i);
        px_d   = pos_x_i;
        py_d   = pos_y_i;
        pz_d   = pos_z_i;
        pk_d   = CW'(peak);
        fz_d   = CW'(peak);
        dir_d  = DIR_PX;
        mask_d = '0;
        vt_d   = VT_AIR;
        wr_addr = {CW'(pos_z_i), CW'(pos_y_i), CW'(pos_x_i)};
        wr_data = new_type_i;
        if (in_acc) begin
          priority if (req_type_i == REQ_WRITE) begin
            wr_en = x_ok && y_ok && z_ok && (new_type_i <= VT_BEDROCK);
          end else if (req_type_i == REQ_FILL) begin
            if (x_ok && y_ok) state_d = S_FILL;
          end else if (req_type_i == REQ_FACES) begin
            if (x_ok && y_ok && z_ok) begin
              rd_en   = 1'b1;
              state_d = S_SELF;
            end else begin
              state_d = S_EMIT;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = {fz_q, cy_q, cx_q};
        priority if (fz_q == '0) wr_data = VT_BEDROCK;
        else if (fz_q == pk_q) wr_data = VT_GRASS;
        else if (fz_gap <= CW'(2)) wr_data = VT_DIRT;
        else wr_data = VT_STONE;
        fz_d = fz_q - CW'(1);
        if (fz_q == '0) state_d = S_IDLE;
      end
      S_SELF: begin
        vt_d = rd_data_q;
        state_d = (rd_data_q == VT_AIR) ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        // Issue the read for dir_q, resolve the one issued last cycle
        rd_addr  = {nz, ny, nx};
        rd_en    = (dir_q < 3'(NumDirs));
        nb_out_d = nb_outside;
        dir_d    = dir_q + 3'd1;
        if (dir_q != DIR_PX) begin
          mask_d[dir_q - 3'd1] = nb_out_q || (rd_data_q == VT_AIR);
        end
        if (dir_q == 3'(NumDirs)) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_vt_d   = vt_q;
          o_x_d    = px_q;
          o_y_d    = py_q;
          o_z_d    = pz_q;
          o_fv_d   = (mask_q != '0);
          o_dir_d  = sel;
          o_sh_d   = shade_of(sel);
          o_last_d = (rem == '0);
          mask_d   = rem;
          if (rem == '0) state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cz_q     <= cz_d;
    px_q     <= px_d;
    py_q     <= py_d;
    pz_q     <= pz_d;
    fz_q     <= fz_d;
    pk_q     <= pk_d;
    vt_q     <= vt_d;
    dir_q    <= dir_d;
    nb_out_q <= nb_out_d;
    mask_q   <= mask_d;
    o_fv_q   <= o_fv_d;
    o_last_q <= o_last_d;
    o_dir_q  <= o_dir_d;
    o_vt_q   <= o_vt_d;
    o_x_q    <= o_x_d;
    o_y_q    <= o_y_d;
    o_z_q    <= o_z_d;
    o_sh_q   <= o_sh_d;
  end

  assign out_valid_o  = out_valid_q;
  assign face_valid_o = o_fv_q;
  assign direction_o  = o_dir_q;
  assign voxel_type_o = o_vt_q;
  assign face_x_o     = o_x_q;
  assign face_y_o     = o_y_q;
  assign face_z_o     = o_z_q;
  assign shade_o      = o_sh_q;
  assign last_o       = o_last_q;

endmodule

[tb/voxel_face_culling_mesher_tb.sv]
`timescale 1ns / 100ps

module voxel_face_culling_mesher_tb;
  import vfcm_pkg::*;

  localparam int Chunk = ChunkSizeDef;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RandWords = 343;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 40;
  localparam int MaxReports = 10;
  // receiver windows, in cycles after the random part starts
  localparam int HoldStart = 100;
  localparam int HoldEnd = 400;
  localparam int FastStart = 1500;
  localparam int FastEnd = 2500;

  typedef struct packed {
    logic       fv;
    logic [2:0] dir;
    logic [2:0] vt;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic [7:0] shade;
    logic       last;
  } face_rec_t;

  typedef struct {
    logic [1:0] req;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic [2:0] nt;
    logic [4:0] h;
    bit         chk;
    face_rec_t  exp;
  } req_word_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] req_type = REQ_WRITE;
  logic [3:0] pos_x = '0;
  logic [3:0] pos_y = '0;
  logic [3:0] pos_z = '0;
  logic [2:0] new_type = VT_AIR;
  logic [4:0] height = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       face_valid;
  logic [2:0] direction;
  logic [2:0] voxel_type;
  logic [3:0] face_x;
  logic [3:0] face_y;
  logic [3:0] face_z;
  logic [7:0] shade;
  logic       last;

  logic [2:0] voxel_map [Chunk*Chunk*Chunk];
  face_rec_t  pending_faces [$];
  req_word_t  directed_words [$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         rx_cycles = 0;
  bit         rand_phase = 1'b0;
  bit         fast_send = 1'b0;

  voxel_face_culling_mesher dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .new_type_i   (new_type),
    .height_i     (height),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .face_valid_o (face_valid),
    .direction_o  (direction),
    .voxel_type_o (voxel_type),
    .face_x_o     (face_x),
    .face_y_o     (face_y),
    .face_z_o     (face_z),
    .shade_o      (shade),
    .last_o       (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int cell_at(int x, int y, int z);
    return x + Chunk * (y + Chunk * z);
  endfunction

  function automatic bit in_chunk(int v);
    return v >= 0 && v < Chunk;
  endfunction

  function automatic req_word_t mk_word(logic [1:0] req, int x, int y, int z,
                                        logic [2:0] nt, int h);
    req_word_t w;
    w.req = req;
    w.x = x[3:0];
    w.y = y[3:0];
    w.z = z[3:0];
    w.nt = nt;
    w.h = h[4:0];
    w.chk = 1'b0;
    w.exp = '0;
    return w;
  endfunction

  // query of an air voxel: one record, not valid, last set
  function automatic req_word_t mk_air_query(int x, int y, int z);
    req_word_t w;
    w = mk_word(REQ_FACES, x, y, z, VT_AIR, 0);
    w.chk = 1'b1;
    w.exp = '{fv: 1'b0, dir: DIR_PX, vt: VT_AIR, x: x[3:0], y: y[3:0], z: z[3:0],
              shade: 8'd0, last: 1'b1};
    return w;
  endfunction

  // Update the voxel map with one request and list the face records it yields.
  task automatic apply_request(input req_word_t w, output face_rec_t recs [6],
                               output int n);
    int peak;
    int layer;
    int zz;
    int xi, yi, zi;
    int nx, ny, nz;
    logic [2:0] vt;
    logic [2:0] d;
    bit vis;
    n = 0;
    xi = int'(w.x);
    yi = int'(w.y);
    zi = int'(w.z);
    unique case (w.req)
      REQ_WRITE: begin
        if (in_chunk(xi) && in_chunk(yi) && in_chunk(zi) && w.nt <= VT_BEDROCK)
          voxel_map[cell_at(xi, yi, zi)] = w.nt;
      end
      REQ_FILL: begin
        if (in_chunk(xi) && in_chunk(yi)) begin
          peak = int'(w.h) + 1;
          if (peak > Chunk - 1) peak = Chunk - 1;
          voxel_map[cell_at(xi, yi, peak)] = VT_GRASS;
          layer = 0;
          for (zz = peak; zz > 0; zz--) begin
            voxel_map[cell_at(xi, yi, zz - 1)] = (layer < 2) ? VT_DIRT : VT_STONE;
            layer++;
          end
          voxel_map[cell_at(xi, yi, 0)] = VT_BEDROCK;
        end
      end
      REQ_FACES: begin
        if (in_chunk(xi) && in_chunk(yi) && in_chunk(zi))
          vt = voxel_map[cell_at(xi, yi, zi)];
        else
          vt = VT_AIR;
        if (vt != VT_AIR) begin
          for (int k = 0; k < NumDirs; k++) begin
            d = k[2:0];
            nx = xi;
            ny = yi;
            nz = zi;
            unique case (d)
              DIR_PX: nx++;
              DIR_PY: ny++;
              DIR_NX: nx--;
              DIR_NY: ny--;
              DIR_PZ: nz++;
              default: nz--;
            endcase
            if (!in_chunk(nx) || !in_chunk(ny) || !in_chunk(nz))
              vis = 1'b1;
            else
              vis = voxel_map[cell_at(nx, ny, nz)] == VT_AIR;
            if (vis) begin
              recs[n] = '{fv: 1'b1, dir: d, vt: vt, x: w.x, y: w.y, z: w.z,
                          shade: 8'((k * 255) / 6), last: 1'b0};
              n++;
            end
          end
        end
        if (n == 0) begin
          recs[0] = '{fv: 1'b0, dir: DIR_PX, vt: vt, x: w.x, y: w.y, z: w.z,
                      shade: 8'd0, last: 1'b1};
          n = 1;
        end else begin
          recs[n-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one word, hold it until accepted, then record what it should yield.
  task automatic send_word(input req_word_t w, input bit may_idle);
    face_rec_t recs [6];
    int n;
    while (may_idle && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= w.req;
    pos_x <= w.x;
    pos_y <= w.y;
    pos_z <= w.z;
    new_type <= w.nt;
    height <= w.h;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    apply_request(w, recs, n);
    if (w.chk) begin
      pending_faces.push_back(w.exp);
    end else begin
      for (int i = 0; i < n; i++) pending_faces.push_back(recs[i]);
    end
  endtask

  // Bias positions toward the low and high ends of each axis so columns pile up and faces get hidden.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 3);
    if (r < 75) return $urandom_range(12, 15);
    return $urandom_range(0, 15);
  endfunction

  function automatic req_word_t random_word();
    int r;
    logic [2:0] nt;
    int h;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 15) nt = 3'($urandom_range(0, 7));
    else nt = 3'($urandom_range(0, 4));
    if ($urandom_range(0, 99) < 80) h = $urandom_range(0, 15);
    else h = $urandom_range(16, 31);
    if (r < 25) return mk_word(REQ_WRITE, pick_coord(), pick_coord(),
                               $urandom_range(0, 15), nt, h);
    if (r < 45) return mk_word(REQ_FILL, pick_coord(), pick_coord(),
                               $urandom_range(0, 15), nt, h);
    if (r < 95) return mk_word(REQ_FACES, pick_coord(), pick_coord(),
                               $urandom_range(0, 15), nt, h);
    return mk_word(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), nt, h);
  endfunction

  task automatic report_face(input string what, input face_rec_t exp, input face_rec_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $write("%s: exp fv=%0d dir=%0d vt=%0d xyz=%0d,%0d,%0d shade=%0d last=%0d | ",
             what, exp.fv, exp.dir, exp.vt, exp.x, exp.y, exp.z, exp.shade, exp.last);
      $display("got fv=%0d dir=%0d vt=%0d xyz=%0d,%0d,%0d shade=%0d last=%0d",
               got.fv, got.dir, got.vt, got.x, got.y, got.z, got.shade, got.last);
    end
  endtask

  // Compare each record word with the oldest pending face.
  initial begin
    face_rec_t got;
    face_rec_t exp;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{fv: face_valid, dir: direction, vt: voxel_type, x: face_x, y: face_y,
                z: face_z, shade: shade, last: last};
        if (pending_faces.size() == 0) begin
          report_face("unexpected record", '0, got);
        end else begin
          exp = pending_faces.pop_front();
          if (got.fv !== exp.fv || got.dir !== exp.dir || got.vt !== exp.vt ||
              got.x !== exp.x || got.y !== exp.y || got.z !== exp.z ||
              got.shade !== exp.shade || got.last !== exp.last)
            report_face("record mismatch", exp, got);
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, one stretch always ready.
  initial begin
    forever begin
      @(posedge clk);
      if (rand_phase) rx_cycles++;
      if (rx_cycles >= HoldStart && rx_cycles < HoldEnd)
        out_ready <= 1'b0;
      else if (rx_cycles >= FastStart && rx_cycles < FastEnd)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= 28);
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("voxel_face_culling_mesher_tb NOT OK");
    $finish;
  end

  initial begin
    int counted;
    req_word_t w;
    foreach (voxel_map[i]) voxel_map[i] = VT_AIR;

    directed_words.push_back(mk_air_query(0, 0, 0));
    directed_words.push_back(mk_word(REQ_WRITE, 0, 0, 0, VT_STONE, 0));
    directed_words.push_back(mk_word(REQ_FACES, 0, 0, 0, VT_AIR, 0));
    // out-of-range type and unknown request leave the map alone
    directed_words.push_back(mk_word(REQ_WRITE, 15, 15, 15, 3'd7, 31));
    directed_words.push_back(mk_air_query(15, 15, 15));
    directed_words.push_back(mk_word(REQ_UNUSED, 15, 15, 15, VT_BEDROCK, 31));
    directed_words.push_back(mk_air_query(15, 15, 15));
    // lowest height: bedrock overrides the dirt layer
    directed_words.push_back(mk_word(REQ_FILL, 5, 5, 0, VT_AIR, 0));
    directed_words.push_back(mk_word(REQ_FACES, 5, 5, 1, VT_AIR, 0));
    directed_words.push_back(mk_word(REQ_FACES, 5, 5, 0, VT_AIR, 0));
    // saturating heights around one column, then a fully hidden voxel
    directed_words.push_back(mk_word(REQ_FILL, 6, 5, 0, VT_AIR, 31));
    directed_words.push_back(mk_word(REQ_FILL, 4, 5, 0, VT_AIR, 16));
    directed_words.push_back(mk_word(REQ_FILL, 5, 6, 0, VT_AIR, 16));
    directed_words.push_back(mk_word(REQ_FILL, 5, 4, 0, VT_AIR, 16));
    directed_words.push_back(mk_word(REQ_FILL, 5, 5, 0, VT_AIR, 16));
    directed_words.push_back(mk_word(REQ_FACES, 5, 5, 5, VT_AIR, 0));
    directed_words.push_back(mk_word(REQ_FACES, 5, 5, 15, VT_AIR, 0));
    directed_words.push_back(mk_word(REQ_WRITE, 5, 5, 15, VT_AIR, 0));
    directed_words.push_back(mk_air_query(5, 5, 15));
    directed_words.push_back(mk_word(REQ_FILL, 9, 9, 0, VT_AIR, 3));
    directed_words.push_back(mk_word(REQ_FACES, 9, 9, 4, VT_AIR, 0));
    directed_words.push_back(mk_word(REQ_FACES, 9, 9, 2, VT_AIR, 0));
    directed_words.push_back(mk_word(REQ_WRITE, 10, 10, 10, VT_DIRT, 0));
    directed_words.push_back(mk_word(REQ_WRITE, 10, 10, 11, VT_GRASS, 0));
    directed_words.push_back(mk_word(REQ_WRITE, 15, 0, 15, VT_BEDROCK, 0));
    directed_words.push_back(mk_word(REQ_FACES, 15, 0, 15, VT_AIR, 0));
    directed_words.push_back(mk_word(REQ_FACES, 10, 10, 11, VT_AIR, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[i]) send_word(directed_words[i], 1'b1);

    rand_phase = 1'b1;
    counted = 0;
    while (counted < RandWords) begin
      w = random_word();
      fast_send = (counted >= 150 && counted < 220);
      send_word(w, !fast_send);
      counted++;
    end
    in_valid <= 1'b0;

    while (pending_faces.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && pending_faces.size() == 0)
      $display("voxel_face_culling_mesher_tb OK");
    else
      $display("voxel_face_culling_mesher_tb NOT OK");
    $finish;
  end

endmodule
